FILE: hdl/lbpm_pkg.sv
// lbpm_pkg: shared types, constants and command/status structs for the light bar pair matcher
// used by lbpm_ctrl, lbpm_datapath and light_bar_pair_matcher_unit
package lbpm_pkg;

    localparam int MAX_LIGHTS_DEF = 16;

    localparam logic [11:0] TILT_GAP_RST   = 12'd240;
    localparam logic [15:0] TILT_SLOPE_RST = 16'd148;
    localparam logic [11:0] LEN_MAX_RST    = 12'd973;
    localparam logic [11:0] LEN_MIN_RST    = 12'd205;
    localparam logic [11:0] HGT_RATIO_RST  = 12'd384;

    localparam logic [16:0] STACK_DX = 17'd160;
    localparam logic [16:0] STACK_DY = 17'd560;

    localparam int SQRT_STEPS = 17;

    typedef enum logic [3:0] {
        VERDICT_OK        = 4'd0,
        VERDICT_COLOR     = 4'd1,
        VERDICT_STACKED   = 4'd2,
        VERDICT_ANGLE     = 4'd3,
        VERDICT_TILT      = 4'd4,
        VERDICT_ZERO      = 4'd5,
        VERDICT_TOO_LONG  = 4'd6,
        VERDICT_TOO_SHORT = 4'd7,
        VERDICT_HEIGHTS   = 4'd8
    } verdict_t;

    localparam logic [2:0] REG_TILT_GAP   = 3'd0;
    localparam logic [2:0] REG_TILT_SLOPE = 3'd1;
    localparam logic [2:0] REG_LEN_MAX    = 3'd2;
    localparam logic [2:0] REG_LEN_MIN    = 3'd3;
    localparam logic [2:0] REG_HGT_RATIO  = 3'd4;

    typedef struct packed {
        logic [11:0] tilt_gap;
        logic [15:0] tilt_slope;
        logic [11:0] len_max;
        logic [11:0] len_min;
        logic [11:0] hgt_ratio;
    } cfg_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] h;
        logic [11:0] tilt;
        logic        color;
    } bar_t;

    // controller to datapath
    typedef struct packed {
        logic load_bar;    // latch incoming bar
        logic read_pair;   // start store read of pair partner
        logic diff;        // compute differences
        logic sqrt_init;   // start square root
        logic sqrt_step;   // one square root iteration
        logic mult;        // ratio products
        logic judge;       // build verdict into output register
        logic store_bar;   // write new bar into store
    } cmd_t;

endpackage

FILE: hdl/light_bar_pair_matcher_unit.sv
// light_bar_pair_matcher_unit: top level, register file and stream ports
// depends on lbpm_pkg, lbpm_ctrl, lbpm_datapath
//
//  channel   | direction | handshake          | contents
//  s_ (bars) | in        | s_tvalid/s_tready  | tuser frame_start, tdata bar fields
//  m_ (pairs)| out       | m_tvalid/m_tready  | tdata verdict fields, tlast last_of_run
//  apb cfg   | in        | psel/penable/pready| five threshold registers at 4*i
//
// a bar is taken only while idle; each stored partner passes through read, diff,
// 17-step square root, products, verdict and output, plus any output stall time
// a bar with an empty store is stored straight away, a bar hitting a full store is dropped
// synchronous active-low reset clears the bar count and loads register defaults
// the store itself is not cleared; only entries below the count are read
module light_bar_pair_matcher_unit
    import lbpm_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // bar_x[15:0], bar_y[31:16], bar_height[47:32],
                                    // bar_tilt[59:48], bar_color[60], zero fill
    input  logic         s_tuser,   // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // first_index[3:0], second_index[7:4], verdict[11:8],
                                    // mid_x[27:12], mid_y[43:28], distance[60:44],
                                    // taller_height[76:61], zero fill
    output logic         m_tlast,   // last_of_run
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);

    cfg_t          cfg_reg;
    cmd_t          cmd;
    bar_t          in_bar;
    logic [IW-1:0] pair_idx, new_idx;
    logic [2:0]    reg_sel;
    logic          cfg_wr;

    logic [3:0]  first_index, second_index, verdict;
    logic [15:0] mid_x, mid_y, taller_height;
    logic [16:0] distance;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tilt_gap   <= TILT_GAP_RST;
            cfg_reg.tilt_slope <= TILT_SLOPE_RST;
            cfg_reg.len_max    <= LEN_MAX_RST;
            cfg_reg.len_min    <= LEN_MIN_RST;
            cfg_reg.hgt_ratio  <= HGT_RATIO_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TILT_GAP:   cfg_reg.tilt_gap   <= pwdata[11:0];
                REG_TILT_SLOPE: cfg_reg.tilt_slope <= pwdata[15:0];
                REG_LEN_MAX:    cfg_reg.len_max    <= pwdata[11:0];
                REG_LEN_MIN:    cfg_reg.len_min    <= pwdata[11:0];
                REG_HGT_RATIO:  cfg_reg.hgt_ratio  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TILT_GAP:   prdata = {20'd0, cfg_reg.tilt_gap};
            REG_TILT_SLOPE: prdata = {16'd0, cfg_reg.tilt_slope};
            REG_LEN_MAX:    prdata = {20'd0, cfg_reg.len_max};
            REG_LEN_MIN:    prdata = {20'd0, cfg_reg.len_min};
            REG_HGT_RATIO:  prdata = {20'd0, cfg_reg.hgt_ratio};
            default:        prdata = '0;
        endcase
    end

    // unpack incoming bar
    assign in_bar.x     = s_tdata[15:0];
    assign in_bar.y     = s_tdata[31:16];
    assign in_bar.h     = s_tdata[47:32];
    assign in_bar.tilt  = s_tdata[59:48];
    assign in_bar.color = s_tdata[60];

    lbpm_ctrl #(
        .MAX_LIGHTS (MAX_LIGHTS),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_frame_start (s_tuser),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_last       (m_tlast),
        .cmd            (cmd),
        .pair_idx       (pair_idx),
        .new_idx        (new_idx)
    );

    lbpm_datapath #(
        .MAX_LIGHTS (MAX_LIGHTS),
        .IW         (IW)
    ) u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .in_bar        (in_bar),
        .pair_idx      (pair_idx),
        .new_idx       (new_idx),
        .first_index   (first_index),
        .second_index  (second_index),
        .verdict       (verdict),
        .mid_x         (mid_x),
        .mid_y         (mid_y),
        .distance      (distance),
        .taller_height (taller_height)
    );

    // pack result transaction
    assign m_tdata = {3'd0, taller_height, distance, mid_y, mid_x,
                      verdict, second_index, first_index};

endmodule

FILE: hdl/lbpm_ctrl.sv
// lbpm_ctrl: sequencer that walks stored bars for each new bar and drives the datapath
// depends on lbpm_pkg
module lbpm_ctrl
    import lbpm_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DEF,
    parameter int IW = $clog2(MAX_LIGHTS),
    parameter int CW = $clog2(MAX_LIGHTS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_frame_start,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_last,
    output cmd_t          cmd,
    output logic [IW-1:0] pair_idx,
    output logic [IW-1:0] new_idx
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_READ  = 8'b00000010,
        ST_DIFF  = 8'b00000100,
        ST_SQRT  = 8'b00001000,
        ST_MULT  = 8'b00010000,
        ST_JUDGE = 8'b00100000,
        ST_OUT   = 8'b01000000,
        ST_STORE = 8'b10000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [4:0]    step_reg, step_next;
    logic          last_reg, last_next;
    logic [CW-1:0] eff_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = last_reg;
    assign pair_idx  = idx_reg;
    assign new_idx   = count_reg[IW-1:0];
    assign eff_count = in_frame_start ? '0 : count_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    count_next = eff_count;
                    idx_next   = '0;
                    if (eff_count < CW'(MAX_LIGHTS)) begin
                        cmd.load_bar = 1'b1;
                        state_next   = (eff_count == '0) ? ST_STORE : ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.read_pair = 1'b1;
                state_next    = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQRT;
                step_next  = '0;
            end
            ST_SQRT: begin
                if (step_reg == '0) begin
                    cmd.sqrt_init = 1'b1;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(SQRT_STEPS)) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_JUDGE;
            end
            ST_JUDGE: begin
                cmd.judge  = 1'b1;
                last_next  = (CW'(idx_reg) + CW'(1) == count_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) begin
                    if (last_reg) begin
                        state_next = ST_STORE;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_STORE: begin
                cmd.store_bar = 1'b1;
                count_next    = count_reg + CW'(1);
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/lbpm_datapath.sv
// lbpm_datapath: bar store, differences, iterative square root, ratio products, verdict
// depends on lbpm_pkg
module lbpm_datapath
    import lbpm_pkg::*;
#(
    parameter int MAX_LIGHTS = MAX_LIGHTS_DEF,
    parameter int IW = $clog2(MAX_LIGHTS)
) (
    input  logic          aclk,
    input  cmd_t          cmd,
    input  cfg_t          cfg,
    input  bar_t          in_bar,
    input  logic [IW-1:0] pair_idx,
    input  logic [IW-1:0] new_idx,
    output logic [3:0]    first_index,
    output logic [3:0]    second_index,
    output logic [3:0]    verdict,
    output logic [15:0]   mid_x,
    output logic [15:0]   mid_y,
    output logic [16:0]   distance,
    output logic [15:0]   taller_height
);

    bar_t bar_mem [MAX_LIGHTS];
    bar_t new_reg, old_reg;

    logic [15:0] dx_reg, dy_reg, hmax_reg, hmin_reg, midx_reg, midy_reg;
    logic [11:0] dtilt_reg;
    logic        color_ne_reg;
    logic [33:0] rem_reg;
    logic [16:0] root_reg;
    logic [4:0]  bit_reg;

    logic [32:0] prod_tilt_reg, prod_len_max_reg, prod_len_min_reg, prod_hgt_reg;
    logic [24:0] dy_sh_reg, dist_sh_reg;
    logic [23:0] hmax_sh_reg;

    logic [16:0] sum_x, sum_y;
    logic [15:0] dx_c, dy_c;
    logic [11:0] dt_c;
    logic [31:0] dx_sq, dy_sq;
    logic [33:0] trial;
    logic [33:0] trial_bit;

    always_ff @(posedge aclk) begin
        if (cmd.store_bar) begin
            bar_mem[new_idx] <= new_reg;
        end
        if (cmd.read_pair) begin
            old_reg <= bar_mem[pair_idx];
        end
        if (cmd.load_bar) begin
            new_reg <= in_bar;
        end
    end

    assign dx_c  = (old_reg.x > new_reg.x) ? old_reg.x - new_reg.x : new_reg.x - old_reg.x;
    assign dy_c  = (old_reg.y > new_reg.y) ? old_reg.y - new_reg.y : new_reg.y - old_reg.y;
    assign dt_c  = (old_reg.tilt > new_reg.tilt) ? old_reg.tilt - new_reg.tilt
                                                 : new_reg.tilt - old_reg.tilt;
    assign sum_x = {1'b0, old_reg.x} + {1'b0, new_reg.x};
    assign sum_y = {1'b0, old_reg.y} + {1'b0, new_reg.y};

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            dx_reg       <= dx_c;
            dy_reg       <= dy_c;
            dtilt_reg    <= dt_c;
            color_ne_reg <= old_reg.color != new_reg.color;
            midx_reg     <= sum_x[16:1];
            midy_reg     <= sum_y[16:1];
            hmax_reg     <= (old_reg.h > new_reg.h) ? old_reg.h : new_reg.h;
            hmin_reg     <= (old_reg.h > new_reg.h) ? new_reg.h : old_reg.h;
        end
    end

    // full 32-bit squares of the differences
    assign dx_sq = {16'd0, dx_reg} * {16'd0, dx_reg};
    assign dy_sq = {16'd0, dy_reg} * {16'd0, dy_reg};

    // restoring square root, one result bit per step, 17 steps
    assign trial_bit = 34'd1 << {bit_reg, 1'b0};
    assign trial     = {root_reg, 17'd0} >> (5'd16 - bit_reg) | trial_bit;

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rem_reg  <= {2'b00, dx_sq} + {2'b00, dy_sq};
            root_reg <= '0;
            bit_reg  <= 5'd16;
        end else if (cmd.sqrt_step) begin
            if (rem_reg >= trial) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= root_reg | (17'd1 << bit_reg);
            end
            bit_reg <= bit_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            prod_tilt_reg    <= {17'd0, cfg.tilt_slope} * {17'd0, dx_reg};
            prod_len_max_reg <= {21'd0, cfg.len_max} * {17'd0, hmax_reg};
            prod_len_min_reg <= {21'd0, cfg.len_min} * {17'd0, hmax_reg};
            prod_hgt_reg     <= {21'd0, cfg.hgt_ratio} * {17'd0, hmin_reg};
            dy_sh_reg        <= {1'b0, dy_reg, 8'd0};
            dist_sh_reg      <= {root_reg, 8'd0};
            hmax_sh_reg      <= {hmax_reg, 8'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.judge) begin
            first_index   <= 4'(pair_idx);
            second_index  <= 4'(new_idx);
            mid_x         <= midx_reg;
            mid_y         <= midy_reg;
            distance      <= root_reg;
            taller_height <= hmax_reg;
            if (color_ne_reg) begin
                verdict <= VERDICT_COLOR;
            end else if ({1'b0, dx_reg} < STACK_DX && {1'b0, dy_reg} > STACK_DY) begin
                verdict <= VERDICT_STACKED;
            end else if (dtilt_reg > cfg.tilt_gap) begin
                verdict <= VERDICT_ANGLE;
            end else if ({8'd0, dy_sh_reg} > prod_tilt_reg) begin
                verdict <= VERDICT_TILT;
            end else if (hmin_reg == '0) begin
                verdict <= VERDICT_ZERO;
            end else if ({8'd0, dist_sh_reg} > prod_len_max_reg) begin
                verdict <= VERDICT_TOO_LONG;
            end else if ({8'd0, dist_sh_reg} < prod_len_min_reg) begin
                verdict <= VERDICT_TOO_SHORT;
            end else if ({9'd0, hmax_sh_reg} > prod_hgt_reg) begin
                verdict <= VERDICT_HEIGHTS;
            end else begin
                verdict <= VERDICT_OK;
            end
        end
    end

endmodule
